>>> hw/rtl/d2b64_pkg.sv
// Package for the double to base-64 float converter.
// Holds status codes, field widths and the shared decode result type; no dependencies.
package d2b64_pkg;

    localparam int DigitW = 6;
    localparam int ExpW   = 9;

    localparam logic [1:0] StatusOk    = 2'd0;
    localparam logic [1:0] StatusRange = 2'd1;
    localparam logic [1:0] StatusZero  = 2'd2;
    localparam logic [1:0] StatusSpec  = 2'd3;

    localparam logic [5:0] HalfDigit = 6'd32;
    localparam logic [8:0] ExpBias   = 9'sd32;

    // Result of the front stage: normalized five-digit window and exponent.
    typedef struct packed {
        logic                     sign;
        logic [29:0]              mant;
        logic signed [ExpW-1:0]   expo;
        logic [1:0]               status;
    } front_t;

endpackage

>>> hw/rtl/d2b64_norm.sv
// Front logic of the converter: decodes the binary64 fields and aligns the
// significand to a five-digit base-64 window. Uses d2b64_pkg.
module d2b64_norm (
    input  logic [63:0]       double_bits,
    output d2b64_pkg::front_t front
);

    logic        sgn;
    logic [10:0] efield;
    logic [51:0] frac;
    logic [52:0] m;
    logic [5:0]  q;
    logic signed [12:0] k;
    logic signed [12:0] p;
    logic [11:0] pb;
    logic [27:0] prod;
    logic signed [12:0] fl;
    logic signed [12:0] r;
    logic signed [7:0]  s;
    logic [82:0] shl;
    logic [52:0] shr;

    assign sgn    = double_bits[63];
    assign efield = double_bits[62:52];
    assign frac   = double_bits[51:0];

    always_comb
    begin
        q = 6'd0;
        for (int i = 0; i < 53; i++)
        begin
            if (m[i])
            begin
                q = 6'(i);
            end
        end
    end

    always_comb
    begin
        if (efield == 11'd0)
        begin
            m = {1'b0, frac};
            k = -13'sd1074;
        end
        else
        begin
            m = {1'b1, frac};
            k = $signed({2'b00, efield}) - 13'sd1075;
        end
        p = k + $signed({7'd0, q});
        // Floor division by six: p+1200 keeps the operand positive and below
        // 2^12, where multiplying by 43691 and dropping 18 bits is exact.
        pb   = 12'(p + 13'sd1200);
        prod = {16'd0, pb} * 28'd43691;
        fl   = $signed({3'b000, prod[27:18]}) - 13'sd200;
        r  = p - 13'(fl * 13'sd6);
        s  = 8'(13'sd24 + r - $signed({7'd0, q}));
        shl = {30'd0, m} << s[4:0];
        shr = m >> 6'(-s);
    end

    always_comb
    begin
        front.sign = sgn;
        front.mant = (s >= 0) ? shl[29:0] : shr[29:0];
        front.expo = 9'(fl + 13'sd33);
        if (efield == 11'h7FF)
        begin
            front.status = d2b64_pkg::StatusSpec;
            front.sign   = (frac == 52'd0) ? sgn : 1'b0;
        end
        else if (efield == 11'd0 && frac == 52'd0)
        begin
            front.status = d2b64_pkg::StatusZero;
            front.sign   = 1'b0;
        end
        else
        begin
            front.status = d2b64_pkg::StatusOk;
        end
    end

endmodule

>>> hw/rtl/d2b64_round.sv
// Back logic of the converter: rounds on the fifth digit, renormalizes a
// carry out of the leading digit and sets the range status. Uses d2b64_pkg.
module d2b64_round (
    input  d2b64_pkg::front_t front,
    output logic        sign_o,
    output logic [23:0] digits_o,
    output logic signed [8:0] expo_o,
    output logic [1:0]  status_o
);

    logic [5:0]  d5;
    logic        inc;
    logic [24:0] top;
    logic signed [8:0] ex;

    always_comb
    begin
        d5  = front.mant[5:0];
        inc = (d5 > d2b64_pkg::HalfDigit) ||
              (d5 == d2b64_pkg::HalfDigit && !front.mant[6]);
        top = {1'b0, front.mant[29:6]} + {24'd0, inc};
        ex  = front.expo;
        if (top[24])
        begin
            top = 25'd1 << 18;
            ex  = ex + 9'sd1;
        end
        sign_o = front.sign;
        if (front.status != d2b64_pkg::StatusOk)
        begin
            digits_o = 24'd0;
            expo_o   = 9'sd0;
            status_o = front.status;
        end
        else
        begin
            digits_o = top[23:0];
            expo_o   = ex;
            status_o = (ex < 0 || ex > 9'sd63) ? d2b64_pkg::StatusRange
                                               : d2b64_pkg::StatusOk;
        end
    end

endmodule

>>> hw/rtl/double_to_base64_float_unit.sv
// Converts one IEEE-754 binary64 encoding per beat into a normalized base-64
// float: sign, four 6-bit digits and an excess-32 exponent with a status code.
// Each beat passes an input register, then a result register; a new beat is
// accepted every cycle unless in_stall is high; the result register holds while
// stalled and the input stage moves on whenever the result register is free or drained.
module double_to_base64_float_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] double_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        sign_bit,
    output logic [5:0]  digit_first,
    output logic [5:0]  digit_second,
    output logic [5:0]  digit_third,
    output logic [5:0]  digit_fourth,
    output logic signed [8:0] biased_exponent,
    output logic [1:0]  status
);

    logic        a_valid_reg;
    logic [63:0] a_bits_reg;
    logic        move_a;
    logic        load_a;
    d2b64_pkg::front_t front;
    logic        r_sign;
    logic [23:0] r_digits;
    logic signed [8:0] r_expo;
    logic [1:0]  r_status;
    logic [23:0] digits_reg;

    assign move_a   = a_valid_reg && (!out_valid || !out_stall);
    assign in_stall = a_valid_reg && !move_a;
    assign load_a   = in_valid && !in_stall;

    d2b64_norm u_norm (
        .double_bits (a_bits_reg),
        .front       (front)
    );

    d2b64_round u_round (
        .front    (front),
        .sign_o   (r_sign),
        .digits_o (r_digits),
        .expo_o   (r_expo),
        .status_o (r_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (load_a || move_a)
            begin
                a_valid_reg <= load_a;
            end
            if (move_a || !out_stall)
            begin
                out_valid <= move_a;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            a_bits_reg <= double_bits;
        end
        if (move_a)
        begin
            sign_bit        <= r_sign;
            digits_reg      <= r_digits;
            biased_exponent <= r_expo;
            status          <= r_status;
        end
    end

    assign digit_first  = digits_reg[23:18];
    assign digit_second = digits_reg[17:12];
    assign digit_third  = digits_reg[11:6];
    assign digit_fourth = digits_reg[5:0];

endmodule

>>> hw/rtl/d2b64_checker.sv
// Port-level checker for double_to_base64_float_unit, bound to the top level.
// Uses d2b64_pkg status codes.
module d2b64_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [5:0]  digit_first,
    input logic [5:0]  digit_second,
    input logic signed [8:0] biased_exponent,
    input logic [1:0]  status
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("result beat changed while stalled");

    a_lead: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == d2b64_pkg::StatusOk || status == d2b64_pkg::StatusRange)
        |-> digit_first != 6'd0)
        else $error("leading digit zero on a converted beat");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == d2b64_pkg::StatusZero || status == d2b64_pkg::StatusSpec)
        |-> digit_first == 6'd0 && digit_second == 6'd0 && biased_exponent == 9'sd0)
        else $error("special beat carries digits");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == d2b64_pkg::StatusOk
        |-> biased_exponent >= 0 && biased_exponent <= 9'sd63)
        else $error("exponent out of range with ok status");

endmodule

bind double_to_base64_float_unit d2b64_checker u_d2b64_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .digit_first     (digit_first),
    .digit_second    (digit_second),
    .biased_exponent (biased_exponent),
    .status          (status)
);

>>> tb/tb_top.sv
// Testbench for double_to_base64_float_unit: drives binary64 encodings and checks
// sign, digits, exponent and status against an in-bench converter. Depends on d2b64_pkg.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic              sign;
        logic [5:0]        d1;
        logic [5:0]        d2;
        logic [5:0]        d3;
        logic [5:0]        d4;
        logic signed [8:0] expo;
        logic [1:0]        status;
    } b64_float_t;

    localparam int IdleLimit = 2000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [63:0] double_bits;
    logic out_valid;
    logic out_stall = 1'b0;
    logic sign_bit;
    logic [5:0] digit_first;
    logic [5:0] digit_second;
    logic [5:0] digit_third;
    logic [5:0] digit_fourth;
    logic signed [8:0] biased_exponent;
    logic [1:0] status;

    b64_float_t expected_floats[$];
    int errors = 0;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;

    double_to_base64_float_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .double_bits(double_bits),
        .out_valid(out_valid), .out_stall(out_stall),
        .sign_bit(sign_bit), .digit_first(digit_first), .digit_second(digit_second),
        .digit_third(digit_third), .digit_fourth(digit_fourth),
        .biased_exponent(biased_exponent), .status(status)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic b64_float_t convert_double(input logic [63:0] bits);
        b64_float_t res;
        logic [10:0] efield;
        logic [51:0] frac;
        logic [52:0] m;
        logic [63:0] mant;
        logic [24:0] top;
        logic [5:0] d5;
        logic [5:0] d4;
        int k, q, p, fl, r, s, ex;
        logic inc;
        res = '0;
        efield = bits[62:52];
        frac = bits[51:0];
        if (efield == 11'h7FF)
        begin
            res.sign = (frac == 0) ? bits[63] : 1'b0;
            res.status = d2b64_pkg::StatusSpec;
            return res;
        end
        if (efield == 0 && frac == 0)
        begin
            res.status = d2b64_pkg::StatusZero;
            return res;
        end
        if (efield == 0)
        begin
            m = {1'b0, frac};
            k = -1074;
        end
        else
        begin
            m = {1'b1, frac};
            k = int'(efield) - 1075;
        end
        q = 0;
        for (int i = 0; i < 53; i++)
            if (m[i])
                q = i;
        p = q + k;
        fl = (p >= 0) ? p / 6 : -((-p + 5) / 6);
        r = p - 6 * fl;
        s = 24 + r - q;
        mant = (s >= 0) ? (64'(m) << s) : (64'(m) >> (-s));
        mant = mant & 64'h3FFF_FFFF;
        d5 = mant[5:0];
        d4 = mant[11:6];
        inc = (d5 > d2b64_pkg::HalfDigit) || (d5 == d2b64_pkg::HalfDigit && !d4[0]);
        ex = fl + 33;
        top = 25'(mant[29:6]) + inc;
        if (top[24])
        begin
            top = 25'd1 << 18;
            ex = ex + 1;
        end
        res.sign = bits[63];
        res.d1 = top[23:18];
        res.d2 = top[17:12];
        res.d3 = top[11:6];
        res.d4 = top[5:0];
        res.expo = 9'(ex);
        res.status = (ex < 0 || ex > 63) ? d2b64_pkg::StatusRange : d2b64_pkg::StatusOk;
        return res;
    endfunction

    // Leaves in_valid high after the beat is taken; the next call drives it again or the
    // drain lowers it, so the signal is assigned only once per time step.
    task automatic send_double(input logic [63:0] bits);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        double_bits <= bits;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_floats.push_back(convert_double(bits));
    endtask

    // Receiver stall and result checking.
    always @(posedge clk)
    begin
        b64_float_t exp_f;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_floats.size() == 0)
                begin
                    $error("result beat with no expectation");
                    errors++;
                end
                else
                begin
                    exp_f = expected_floats.pop_front();
                    if (sign_bit !== exp_f.sign)
                    begin
                        $error("sign_bit exp %0h got %0h", exp_f.sign, sign_bit);
                        errors++;
                    end
                    if (digit_first !== exp_f.d1)
                    begin
                        $error("digit_first exp %0d got %0d", exp_f.d1, digit_first);
                        errors++;
                    end
                    if (digit_second !== exp_f.d2)
                    begin
                        $error("digit_second exp %0d got %0d", exp_f.d2, digit_second);
                        errors++;
                    end
                    if (digit_third !== exp_f.d3)
                    begin
                        $error("digit_third exp %0d got %0d", exp_f.d3, digit_third);
                        errors++;
                    end
                    if (digit_fourth !== exp_f.d4)
                    begin
                        $error("digit_fourth exp %0d got %0d", exp_f.d4, digit_fourth);
                        errors++;
                    end
                    if (biased_exponent !== exp_f.expo)
                    begin
                        $error("biased_exponent exp %0d got %0d", exp_f.expo,
                               biased_exponent);
                        errors++;
                    end
                    if (status !== exp_f.status)
                    begin
                        $error("status exp %0d got %0d", exp_f.status, status);
                        errors++;
                    end
                end
            end
            out_stall <= (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on cycles where no beat moves.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [63:0] make_double(input logic sgn, input logic [10:0] e,
                                                input logic [51:0] f);
        return {sgn, e, f};
    endfunction

    function automatic logic [51:0] rand_frac();
        return 52'({$urandom, $urandom});
    endfunction

    task automatic test_special_values();
        send_double(64'h0000_0000_0000_0000);
        send_double(64'h8000_0000_0000_0000);
        send_double(64'h7FF0_0000_0000_0000);
        send_double(64'hFFF0_0000_0000_0000);
        send_double(64'h7FF8_0000_0000_0000);
        send_double(64'hFFFF_FFFF_FFFF_FFFF);
        send_double(64'h0000_0000_0000_0001);
        send_double(64'h800F_FFFF_FFFF_FFFF);
        send_double(64'h0010_0000_0000_0000);
        send_double(64'h7FEF_FFFF_FFFF_FFFF);
        send_double(64'h3FF0_0000_0000_0000);
        send_double(64'hBFE0_0000_0000_0000);
    endtask

    // Values near the rounding point and the carry out of the leading digit.
    task automatic test_rounding();
        send_double(64'h3FEF_FFFF_FFFF_FFFF);
        send_double(64'h3FEF_FFFF_F800_0000);
        send_double(64'h3FEF_FFFF_F000_0000);
        send_double(64'h3F8F_FFFF_FFFF_FFFF);
        send_double(64'h3FF0_0000_0200_0000);
        send_double(64'h3FF0_0000_0600_0000);
        send_double(64'h3FF0_0000_0400_0000);
        send_double(64'h4150_0000_0000_0000);
        send_double(64'h4160_0000_0000_0000);
        send_double(64'h3D10_0000_0000_0000);
        send_double(64'h3D00_0000_0000_0000);
    endtask

    task automatic test_random_doubles(input int count);
        logic [10:0] e;
        logic [51:0] f;
        for (int i = 0; i < count; i++)
        begin
            f = rand_frac();
            case ($urandom_range(9))
                0: e = 11'd0;
                1: e = 11'h7FF;
                2: e = 11'(1023 + $urandom_range(180) - 90) ;
                3: f[27:0] = {$urandom_range(1) ? 4'h8 : 4'h0, 24'h0} | (f[27:0] & 28'h8000000);
                default: e = 11'($urandom_range(2046) + 1);
            endcase
            if (e === 11'bx)
                e = 11'($urandom_range(2046) + 1);
            if ($urandom_range(19) == 0)
                f = f & ~52'hFFF_FFFF;
            send_double(make_double(1'($urandom_range(1)), e, f));
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_floats.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
    endtask

    initial
    begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        double_bits = '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_values();
        test_rounding();
        test_random_doubles(340);
        send_idle_pct = 70;
        test_random_doubles(330);
        send_idle_pct = 0;
        recv_stall_pct = 70;
        test_random_doubles(330);
        send_idle_pct = 6;
        recv_stall_pct = 6;
        test_random_doubles(330);
        recv_stall_pct = 0;
        drain_results();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/d2b64_pkg.sv
hw/rtl/d2b64_norm.sv
hw/rtl/d2b64_round.sv
hw/rtl/double_to_base64_float_unit.sv
hw/rtl/d2b64_checker.sv
tb/tb_top.sv
